@@ sv/mcr_pkg.sv @@
// shared widths, codes and field positions of the midpoint circle rasterizer
// no dependencies; imported by the core, its port checker and the testbench
package mcr_pkg;

	// coordinate wrap width of the pixel sums
	localparam int COORD_BITS = 16;

	localparam int RADIUS_W = 14;
	localparam int CENTRE_W = 15;
	localparam int PIX_W    = 16;
	localparam int OCT_W    = 3;
	localparam int DEC_W    = 17;

	// sum width wide enough for offset plus centre and for the wrap width
	localparam int SUM_W = (COORD_BITS > CENTRE_W + 2) ? COORD_BITS : CENTRE_W + 2;

	localparam int IN_TDATA_W  = 48;
	localparam int OUT_TDATA_W = 40;

	localparam logic [OCT_W-1:0] OCT_FIRST = '0;
	localparam logic [OCT_W-1:0] OCT_LAST  = '1;

	typedef enum logic {
		FUNC_START = 1'b0,
		FUNC_STEP  = 1'b1
	} func_t;

endpackage

@@ sv/midpoint_circle_rasterizer_core.sv @@
// midpoint circle rasterizer: start and step items in, one pixel item per cycle out while not stalled
// depends on mcr_pkg for widths and codes
//
// usage
//   slave channel s_axis_*: one item per handshake; tuser carries the function
//   (start a circle or advance one step), tdata carries radius and centre
//   master channel m_axis_*: pixel items, tlast marks the last item of a step,
//   tuser flags a finished circle (or a step given while idle)
//   a start item loads the generator and produces no item
//   a step item produces eight pixels, octants 0 to 7 in order, one per cycle unless stalled;
//   a step while idle produces a single item with zero coordinates
// path: an accepted step enters the step register, and its pixels reach m_axis through the output register
// throughput: one pixel per cycle while m_axis_tready is high; the octant
//   counter of the step register walks the octants; the next step is accepted
//   in the cycle its predecessor's last pixel moves to the output register
// reset: arst_n clears the generator to idle and empties both registers
// stall: when m_axis_tready is low a full output register holds its item, the
//   step register holds, and s_axis_tready drops until the step can finish
module midpoint_circle_rasterizer_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// [13:0] radius, [28:14] centre_x, [43:29] centre_y, [47:44] zero
	input  logic [mcr_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
	// [0] func
	input  logic                            s_axis_tuser,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// [15:0] pix_x, [31:16] pix_y, [34:32] octant, [39:35] zero
	output logic [mcr_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	// last_of_step
	output logic                            m_axis_tlast,
	// [0] done_res
	output logic                            m_axis_tuser
);
	import mcr_pkg::*;

	// generator state
	logic        [RADIUS_W-1:0] cur_x_q, cur_y_q;
	logic signed [DEC_W-1:0]    dec_q;
	logic signed [CENTRE_W-1:0] cx_q, cy_q;
	logic                       active_q;

	// step register: one accepted step being unrolled into pixels
	logic                       busy_s1;
	logic                       idle_s1;
	logic                       fin_s1;
	logic        [OCT_W-1:0]    oct_s1;
	logic        [RADIUS_W-1:0] x_s1, y_s1;
	logic signed [CENTRE_W-1:0] cx_s1, cy_s1;

	// output register
	logic                       out_valid_s2;
	logic        [PIX_W-1:0]    pix_x_s2, pix_y_s2;
	logic        [OCT_W-1:0]    oct_s2;
	logic                       last_s2, done_s2;

	// input fields
	logic        [RADIUS_W-1:0] in_radius;
	logic signed [CENTRE_W-1:0] in_cx, in_cy;
	func_t                      in_func;
	logic                       accept, load_out, step_end;

	assign in_radius = s_axis_tdata[RADIUS_W-1:0];
	assign in_cx     = s_axis_tdata[RADIUS_W+CENTRE_W-1:RADIUS_W];
	assign in_cy     = s_axis_tdata[RADIUS_W+2*CENTRE_W-1:RADIUS_W+CENTRE_W];
	assign in_func   = func_t'(s_axis_tuser);

	// the output register takes a pixel when empty or drained this cycle
	assign load_out      = busy_s1 && (!out_valid_s2 || m_axis_tready);
	assign step_end      = load_out && (idle_s1 || oct_s1 == OCT_LAST);
	assign s_axis_tready = !busy_s1 || step_end;
	assign accept        = s_axis_tvalid && s_axis_tready;

	// decision update for the step about to be taken
	logic signed [DEC_W:0]      inc_in, inc_out, dec_wide;
	logic signed [DEC_W-1:0]    dec_next;
	logic signed [RADIUS_W:0]   x_next, y_next;
	logic                       dec_neg, fin_next;

	always_comb begin
		dec_neg  = dec_q < 0;
		inc_in   = $signed({{(DEC_W-RADIUS_W){1'b0}}, cur_x_q, 1'b0}) + (DEC_W+1)'(3);
		inc_out  = $signed({{(DEC_W-RADIUS_W){1'b0}}, cur_x_q, 1'b0})
			- $signed({{(DEC_W-RADIUS_W){1'b0}}, cur_y_q, 1'b0}) + (DEC_W+1)'(5);
		dec_wide = (DEC_W+1)'(dec_q) + (dec_neg ? inc_in : inc_out);
		dec_next = dec_wide[DEC_W-1:0];
		x_next   = $signed({1'b0, cur_x_q}) + (RADIUS_W+1)'(1);
		// y moves inward only when the midpoint lies outside the circle
		y_next   = $signed({1'b0, cur_y_q}) - (dec_neg ? (RADIUS_W+1)'(0) : (RADIUS_W+1)'(1));
		fin_next = x_next > y_next;
	end

	// generator state and step register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_x_q  <= '0;
			cur_y_q  <= '0;
			dec_q    <= '0;
			cx_q     <= '0;
			cy_q     <= '0;
			active_q <= 1'b0;
			busy_s1  <= 1'b0;
			oct_s1   <= OCT_FIRST;
		end else begin
			if (accept && in_func == FUNC_START) begin
				// a start abandons any circle in progress
				cur_x_q  <= '0;
				cur_y_q  <= in_radius;
				dec_q    <= DEC_W'(1) - $signed({{(DEC_W-RADIUS_W){1'b0}}, in_radius});
				cx_q     <= in_cx;
				cy_q     <= in_cy;
				active_q <= 1'b1;
			end else if (accept && active_q) begin
				dec_q <= dec_next;
				if (fin_next) begin
					active_q <= 1'b0;
				end else begin
					cur_x_q <= x_next[RADIUS_W-1:0];
					cur_y_q <= y_next[RADIUS_W-1:0];
				end
			end

			if (accept && in_func == FUNC_STEP) begin
				busy_s1 <= 1'b1;
				oct_s1  <= OCT_FIRST;
			end else if (step_end) begin
				busy_s1 <= 1'b0;
			end else if (load_out) begin
				oct_s1 <= oct_s1 + OCT_W'(1);
			end
		end
	end

	// step payload, no reset needed
	always_ff @(posedge clk) begin
		if (accept && in_func == FUNC_STEP) begin
			idle_s1 <= !active_q;
			fin_s1  <= fin_next;
			x_s1    <= cur_x_q;
			y_s1    <= cur_y_q;
			cx_s1   <= cx_q;
			cy_s1   <= cy_q;
		end
	end

	// octant mapping: pick magnitude and sign for each axis
	logic                       sel_x_is_y, sel_y_is_y, neg_x, neg_y;
	logic signed [CENTRE_W-1:0] off_x, off_y;
	logic signed [SUM_W-1:0]    sum_x, sum_y;
	logic signed [COORD_BITS-1:0] wrap_x, wrap_y;
	logic        [PIX_W-1:0]    pix_x, pix_y;

	always_comb begin
		unique case (oct_s1)
			3'd0: begin sel_x_is_y = 1'b0; sel_y_is_y = 1'b1; neg_x = 1'b0; neg_y = 1'b0; end
			3'd1: begin sel_x_is_y = 1'b1; sel_y_is_y = 1'b0; neg_x = 1'b0; neg_y = 1'b0; end
			3'd2: begin sel_x_is_y = 1'b1; sel_y_is_y = 1'b0; neg_x = 1'b1; neg_y = 1'b0; end
			3'd3: begin sel_x_is_y = 1'b0; sel_y_is_y = 1'b1; neg_x = 1'b1; neg_y = 1'b0; end
			3'd4: begin sel_x_is_y = 1'b0; sel_y_is_y = 1'b1; neg_x = 1'b1; neg_y = 1'b1; end
			3'd5: begin sel_x_is_y = 1'b1; sel_y_is_y = 1'b0; neg_x = 1'b1; neg_y = 1'b1; end
			3'd6: begin sel_x_is_y = 1'b1; sel_y_is_y = 1'b0; neg_x = 1'b0; neg_y = 1'b1; end
			default: begin sel_x_is_y = 1'b0; sel_y_is_y = 1'b1; neg_x = 1'b0; neg_y = 1'b1; end
		endcase
		off_x = $signed({1'b0, sel_x_is_y ? y_s1 : x_s1});
		off_y = $signed({1'b0, sel_y_is_y ? y_s1 : x_s1});
		if (neg_x) off_x = -off_x;
		if (neg_y) off_y = -off_y;
		// wrap to the coordinate width, then sign-extend or trim to the field
		sum_x  = SUM_W'(off_x) + SUM_W'(cx_s1);
		sum_y  = SUM_W'(off_y) + SUM_W'(cy_s1);
		wrap_x = sum_x[COORD_BITS-1:0];
		wrap_y = sum_y[COORD_BITS-1:0];
		pix_x  = PIX_W'(wrap_x);
		pix_y  = PIX_W'(wrap_y);
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (load_out) begin
			out_valid_s2 <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			if (idle_s1) begin
				// step while idle: one item, zero coordinates, done
				pix_x_s2 <= '0;
				pix_y_s2 <= '0;
				oct_s2   <= OCT_FIRST;
				last_s2  <= 1'b1;
				done_s2  <= 1'b1;
			end else begin
				pix_x_s2 <= pix_x;
				pix_y_s2 <= pix_y;
				oct_s2   <= oct_s1;
				last_s2  <= oct_s1 == OCT_LAST;
				done_s2  <= oct_s1 == OCT_LAST && fin_s1;
			end
		end
	end

	assign m_axis_tvalid = out_valid_s2;
	assign m_axis_tdata  = {(OUT_TDATA_W-2*PIX_W-OCT_W)'(0), oct_s2, pix_y_s2, pix_x_s2};
	assign m_axis_tlast  = last_s2;
	assign m_axis_tuser  = done_s2;

endmodule

@@ sv/mcr_checker.sv @@
// port-level checks for the midpoint circle rasterizer core
// depends on mcr_pkg; bound to midpoint_circle_rasterizer_core below
module mcr_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            m_axis_tvalid,
	input logic                            m_axis_tready,
	input logic [mcr_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	input logic                            m_axis_tlast,
	input logic                            m_axis_tuser
);
	import mcr_pkg::*;

	logic [OCT_W-1:0] oct;
	assign oct = m_axis_tdata[2*PIX_W+OCT_W-1:2*PIX_W];

	// a stalled item stays on the bus
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output item dropped or changed under stall");

	// done only on the last item of a step
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
		else $error("done flagged on an item that is not last of step");

	// last item is octant seven, or the lone zero item of an idle step
	a_last_oct: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast |->
		oct == OCT_LAST || (oct == OCT_FIRST && m_axis_tuser && m_axis_tdata == '0))
		else $error("last item of step carries a wrong octant");

	// within a step octants climb by one from item to item
	a_oct_seq: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && !m_axis_tlast ##1 m_axis_tvalid
		|-> oct == $past(oct) + OCT_W'(1))
		else $error("octant order broken within a step");

endmodule

bind midpoint_circle_rasterizer_core mcr_checker u_mcr_checker (.*);

@@ test/tb_midpoint_circle_rasterizer_core.sv @@
// testbench for midpoint_circle_rasterizer_core: directed and random start/step items,
// pixel items checked against an in-bench circle predictor
// depends on mcr_pkg and midpoint_circle_rasterizer_core
module tb_midpoint_circle_rasterizer_core;
	import mcr_pkg::*;

	// long enough for every item at its most pixels, each behind the longest stall
	localparam int CYCLE_LIMIT  = 200000;
	localparam int RANDOM_ITEMS = 240;
	// cycles allowed after the last expected pixel before the verdict
	localparam int DRAIN_CYCLES = 16;

	// one expected pixel item
	typedef struct packed {
		logic signed [PIX_W-1:0] px;
		logic signed [PIX_W-1:0] py;
		logic [OCT_W-1:0]        oct;
		logic                    last;
		logic                    done;
	} pixel_t;

	logic                   clk;
	logic                   arst_n;
	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata;
	logic                   s_axis_tuser;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic                   m_axis_tlast;
	logic                   m_axis_tuser;

	// predictor copy of the generator state
	logic [RADIUS_W-1:0]        gen_x;
	logic [RADIUS_W-1:0]        gen_y;
	logic signed [DEC_W-1:0]    gen_d;
	logic signed [CENTRE_W-1:0] gen_cx;
	logic signed [CENTRE_W-1:0] gen_cy;
	bit                         gen_active;

	pixel_t pixel_q[$];
	int     errors;
	int     items_sent;
	int     cycle_count;
	// when set, neither side inserts gaps or stalls
	bit     no_gaps;

	midpoint_circle_rasterizer_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

	always #1 clk = ~clk;

	// watchdog: a hung handshake ends the run as a failure
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout at %0t with %0d pixels outstanding", $time, pixel_q.size());
			$display("[midpoint_circle_rasterizer_core] ERROR");
			$finish;
		end
	end

	// works out the pixels one accepted item causes and queues them in order
	function automatic void rasterize_item(input func_t f, input logic [RADIUS_W-1:0] r,
			input logic signed [CENTRE_W-1:0] cx, input logic signed [CENTRE_W-1:0] cy);
		int     x;
		int     y;
		int     d;
		int     ox[8];
		int     oy[8];
		bit     fin;
		pixel_t p;
		if (f == FUNC_START) begin
			// a start always reloads, abandoning any circle in progress
			gen_x      = '0;
			gen_y      = r;
			gen_d      = DEC_W'(1 - int'(r));
			gen_cx     = cx;
			gen_cy     = cy;
			gen_active = 1'b1;
		end else if (!gen_active) begin
			// step while idle: one zero pixel flagged last and done
			p      = '0;
			p.oct  = OCT_FIRST;
			p.last = 1'b1;
			p.done = 1'b1;
			pixel_q.push_back(p);
		end else begin
			x  = int'(gen_x);
			y  = int'(gen_y);
			d  = int'(gen_d);
			// octant order, coincident points at x == 0 and x == y kept
			ox = '{x, y, -y, -x, -x, -y, y, x};
			oy = '{y, x, x, y, -y, -x, -x, -y};
			if (d < 0) begin
				d += 2 * x + 3;
			end else begin
				d += 2 * (x - y) + 5;
				y--;
			end
			x++;
			fin = x > y;
			for (int k = 0; k < 8; k++) begin
				// wrap to the coordinate width, then sign-extend or trim to the field
				p.px   = PIX_W'(COORD_BITS'(ox[k] + int'(gen_cx)));
				p.py   = PIX_W'(COORD_BITS'(oy[k] + int'(gen_cy)));
				p.oct  = OCT_W'(k);
				p.last = (OCT_W'(k) == OCT_LAST);
				p.done = (OCT_W'(k) == OCT_LAST) && fin;
				pixel_q.push_back(p);
			end
			gen_d = DEC_W'(d);
			if (fin) begin
				gen_active = 1'b0;
			end else begin
				gen_x = RADIUS_W'(x);
				gen_y = RADIUS_W'(y);
			end
		end
	endfunction

	// offers one item after a random gap, predicts on acceptance, returns at the falling edge
	task automatic send_item(input func_t f, input logic [RADIUS_W-1:0] r,
			input logic signed [CENTRE_W-1:0] cx, input logic signed [CENTRE_W-1:0] cy);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 4);
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= f;
		s_axis_tdata  <= {4'b0, cy, cx, r};
		do @(posedge clk); while (!s_axis_tready);
		rasterize_item(f, r, cx, cy);
		items_sent++;
		@(negedge clk);
	endtask

	// start a circle, then step until it completes or max_steps have gone in
	task automatic run_circle(input logic [RADIUS_W-1:0] r, input logic signed [CENTRE_W-1:0] cx,
			input logic signed [CENTRE_W-1:0] cy, input int max_steps);
		int n;
		n = 0;
		send_item(FUNC_START, r, cx, cy);
		while (gen_active && n < max_steps) begin
			// step items carry random, ignored data
			send_item(FUNC_STEP, RADIUS_W'($urandom), CENTRE_W'($urandom),
				CENTRE_W'($urandom));
			n++;
		end
	endtask

	// pixel sink: random stall before every item, held ready until the item moves
	initial begin
		m_axis_tready = 1'b0;
		wait (arst_n);
		@(negedge clk);
		forever begin : pixel_sink
			int stall;
			stall = no_gaps ? 0 : $urandom_range(0, 4);
			if (stall != 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
			@(negedge clk);
		end
	end

	// compares each accepted pixel with the oldest expectation, field by field
	always @(posedge clk) begin : pixel_check
		pixel_t want;
		logic signed [PIX_W-1:0] got_x;
		logic signed [PIX_W-1:0] got_y;
		logic [OCT_W-1:0]        got_oct;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got_x   = m_axis_tdata[15:0];
			got_y   = m_axis_tdata[31:16];
			got_oct = m_axis_tdata[34:32];
			if (pixel_q.size() == 0) begin
				$display("%0t unexpected pixel: expected none, actual x %0d y %0d octant %0d",
					$time, got_x, got_y, got_oct);
				errors++;
			end else begin
				want = pixel_q.pop_front();
				if (got_x !== want.px) begin
					$display("%0t pix_x: expected %0d, actual %0d", $time, want.px, got_x);
					errors++;
				end
				if (got_y !== want.py) begin
					$display("%0t pix_y: expected %0d, actual %0d", $time, want.py, got_y);
					errors++;
				end
				if (got_oct !== want.oct) begin
					$display("%0t octant: expected %0d, actual %0d", $time, want.oct, got_oct);
					errors++;
				end
				if (m_axis_tlast !== want.last) begin
					$display("%0t last_of_step: expected %0b, actual %0b",
						$time, want.last, m_axis_tlast);
					errors++;
				end
				if (m_axis_tuser !== want.done) begin
					$display("%0t done_res: expected %0b, actual %0b",
						$time, want.done, m_axis_tuser);
					errors++;
				end
			end
		end
	end

	// step straight after reset finds the generator idle
	task automatic test_idle_step();
		send_item(FUNC_STEP, '0, '0, '0);
		send_item(FUNC_STEP, '1, '1, '1);
	endtask

	// radius zero: eight copies of the centre, done on the first step, then idle
	task automatic test_zero_radius();
		run_circle('0, 15'sd0, 15'sd0, 4);
		run_circle('0, -15'sd16384, 15'sd16383, 4);
		send_item(FUNC_STEP, '0, '0, '0);
	endtask

	// largest radius against both centre extremes, abandoned by a new start
	task automatic test_extreme_coords();
		run_circle('1, -15'sd16384, 15'sd16383, 2);
		run_circle('1, 15'sd16383, -15'sd16384, 2);
		// start while active, smallest nonzero radius at the far corner
		run_circle(14'd1, 15'sd16383, 15'sd16383, 4);
	endtask

	// radius 3 reaches x == y; radius 5 is a full circle with back to back items
	task automatic test_small_circles();
		run_circle(14'd3, -15'sd7, 15'sd11, 8);
		no_gaps = 1'b1;
		run_circle(14'd5, 15'sd100, -15'sd200, 8);
		send_item(FUNC_STEP, '0, '0, '0);
		no_gaps = 1'b0;
	endtask

	// mostly complete circles with random centres, some abandoned, some noise
	task automatic test_random_traffic();
		int target;
		int sel;
		target = items_sent + RANDOM_ITEMS;
		while (items_sent < target) begin
			sel     = $urandom_range(0, 99);
			no_gaps = ($urandom_range(0, 4) == 0);
			if (sel < 60) begin
				run_circle(RADIUS_W'($urandom_range(0, 24)), CENTRE_W'($urandom),
					CENTRE_W'($urandom), 1000);
				repeat ($urandom_range(0, 1))
					send_item(FUNC_STEP, RADIUS_W'($urandom), CENTRE_W'($urandom),
						CENTRE_W'($urandom));
			end else if (sel < 80) begin
				// any radius, cut short so the next start abandons it
				run_circle(RADIUS_W'($urandom), CENTRE_W'($urandom), CENTRE_W'($urandom),
					$urandom_range(1, 5));
			end else if (sel < 88) begin
				run_circle(RADIUS_W'($urandom_range(25, 60)), CENTRE_W'($urandom),
					CENTRE_W'($urandom), 1000);
			end else begin
				repeat ($urandom_range(1, 3))
					send_item(func_t'($urandom_range(0, 1)), RADIUS_W'($urandom),
						CENTRE_W'($urandom), CENTRE_W'($urandom));
			end
		end
		no_gaps = 1'b0;
	endtask

	initial begin
		clk           = 1'b0;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = FUNC_START;
		errors        = 0;
		items_sent    = 0;
		cycle_count   = 0;
		no_gaps       = 1'b0;
		gen_x         = '0;
		gen_y         = '0;
		gen_d         = '0;
		gen_cx        = '0;
		gen_cy        = '0;
		gen_active    = 1'b0;
		repeat (9) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_idle_step();
		test_zero_radius();
		test_extreme_coords();
		test_small_circles();
		test_random_traffic();

		s_axis_tvalid <= 1'b0;
		while (pixel_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0) begin
			$display("[midpoint_circle_rasterizer_core] OK");
		end else begin
			$display("[midpoint_circle_rasterizer_core] ERROR");
		end
		$finish;
	end

endmodule

@@ sim.f @@
sv/mcr_pkg.sv
sv/midpoint_circle_rasterizer_core.sv
sv/mcr_checker.sv
test/tb_midpoint_circle_rasterizer_core.sv
